// File: rtl/column_span_sprite_decoder_macros.svh
`ifndef COLUMN_SPAN_SPRITE_DECODER_MACROS_SVH
`define COLUMN_SPAN_SPRITE_DECODER_MACROS_SVH

// property that must hold at every edge out of reset
`define CSD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition at one edge implies a consequence at the next
`define CSD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/csd_pkg.sv
`default_nettype none

package csd_pkg;

  localparam int unsigned PaletteSize = 256;
  localparam int unsigned PalIdxW     = $clog2(PaletteSize);
  localparam int unsigned QueueDepth  = 2;

  localparam logic [1:0] ModePal     = 2'd0;
  localparam logic [1:0] ModeByte    = 2'd1;
  localparam logic [1:0] ModeRestart = 2'd2;

  localparam logic [1:0] KindPixel    = 2'd0;
  localparam logic [1:0] KindEmpty    = 2'd1;
  localparam logic [1:0] KindTooWide  = 2'd2;
  localparam logic [1:0] KindBadStart = 2'd3;

  localparam logic [7:0] RowNone = 8'd255;
  localparam logic [7:0] GlowLo  = 8'd226;
  localparam logic [7:0] GlowHi  = 8'd254;
  localparam logic [17:0] HeaderBytes = 18'd4;

  typedef enum logic [1:0] {
    OP_PAL,
    OP_BYTE,
    OP_RESTART
  } csd_op_e;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_ENTRIES,
    PH_PIXELS,
    PH_DONE
  } csd_phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIX,
    ST_RD,
    ST_CHK
  } csd_state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [7:0] pal_index;
    logic [5:0] pal_red;
    logic [5:0] pal_green;
    logic [5:0] pal_blue;
  } csd_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       opaque;
    logic       glow_index;
    logic       any_glow;
    logic       last;
  } csd_out_t;

  typedef struct packed {
    csd_op_e     op;
    logic [7:0]  data_byte;
    logic [7:0]  pal_index;
    logic [17:0] colour;
  } csd_cmd_t;

  typedef struct packed {
    logic     valid;
    csd_cmd_t cmd;
  } csd_push_t;

endpackage

`default_nettype wire

// File: rtl/csd_front.sv
`default_nettype none

module csd_front (
  input  wire logic               in_valid_i,
  input  wire csd_pkg::csd_in_t   in_i,
  input  wire logic               q_full_i,
  output csd_pkg::csd_push_t      push_o,
  output logic                    in_stall_o
);

  logic known;

  always_comb begin
    push_o.cmd.data_byte = in_i.data_byte;
    push_o.cmd.pal_index = in_i.pal_index;
    push_o.cmd.colour    = {in_i.pal_red, in_i.pal_green, in_i.pal_blue};
    known                = 1'b1;
    case (in_i.mode)
      csd_pkg::ModePal:     push_o.cmd.op = csd_pkg::OP_PAL;
      csd_pkg::ModeByte:    push_o.cmd.op = csd_pkg::OP_BYTE;
      csd_pkg::ModeRestart: push_o.cmd.op = csd_pkg::OP_RESTART;
      default: begin
        // unused mode is dropped here
        push_o.cmd.op = csd_pkg::OP_PAL;
        known         = 1'b0;
      end
    endcase
    push_o.valid = in_valid_i && !q_full_i && known;
  end

  assign in_stall_o = q_full_i;

endmodule

`default_nettype wire

// File: rtl/csd_queue.sv
`default_nettype none

module csd_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire csd_pkg::csd_push_t push_i,
  input  wire logic               pop_i,
  output logic                    full_o,
  output logic                    valid_o,
  output csd_pkg::csd_cmd_t       cmd_o
);

  localparam int unsigned PtrW = $clog2(csd_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(csd_pkg::QueueDepth + 1);

  csd_pkg::csd_cmd_t  slot_q [csd_pkg::QueueDepth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_pop;

  assign full_o  = (count_q == CntW'(csd_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(csd_pkg::QueueDepth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(csd_pkg::QueueDepth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    case ({push_i.valid, do_pop})
      2'b10:   count_d = CntW'(count_q + 1'b1);
      2'b01:   count_d = CntW'(count_q - 1'b1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

`default_nettype wire

// File: rtl/csd_back.sv
`default_nettype none

`include "column_span_sprite_decoder_macros.svh"

module csd_back #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire csd_pkg::csd_cmd_t cmd_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output csd_pkg::csd_out_t      out_o
);

  localparam int unsigned CntW    = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned ColIdxW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned ColDepth = 2 ** ColIdxW;

  // column and palette stores
  logic [15:0] col_mem [ColDepth];
  logic [17:0] pal_mem [csd_pkg::PaletteSize];

  logic                        col_we, col_re;
  logic [ColIdxW-1:0]          col_waddr, col_raddr;
  logic [15:0]                 col_wdata, col_rdata_q;
  logic                        pal_we, pal_re;
  logic [csd_pkg::PalIdxW-1:0] pal_raddr;
  logic [17:0]                 pal_rdata_q;

  csd_pkg::csd_state_e state_q, state_d;
  csd_pkg::csd_phase_e phase_q, phase_d;
  logic [1:0]          bif_q, bif_d;
  logic [15:0]         width_q, width_d;
  logic [15:0]         height_q, height_d;
  logic [15:0]         offset_q, offset_d;
  logic [CntW-1:0]     col_q, col_d;
  logic [CntW-1:0]     cand_q, cand_d;
  logic [7:0]          row_q, row_d;
  logic [7:0]          end_q, end_d;
  logic [7:0]          lo_q, lo_d;
  logic [7:0]          pix_q, pix_d;
  logic                glow_q, glow_d;
  logic                from_pix_q, from_pix_d;
  csd_pkg::csd_out_t   pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  csd_pkg::csd_out_t   out_q, out_d;

  logic              slot_free;
  logic [15:0]       width_new;
  logic [CntW-1:0]   col_next;
  logic [17:0]       expect_off;
  logic              is_glow;
  csd_pkg::csd_out_t pix_res;
  csd_pkg::csd_out_t fin_res;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign width_new   = {cmd_i.data_byte, width_q[7:0]};
  assign col_next    = CntW'(col_q + 1'b1);
  assign expect_off  = csd_pkg::HeaderBytes + {width_q, 2'b00};
  assign is_glow     = (cmd_i.data_byte >= csd_pkg::GlowLo) &&
                       (cmd_i.data_byte <= csd_pkg::GlowHi);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    pix_res            = '0;
    pix_res.kind       = csd_pkg::KindPixel;
    pix_res.pixel_x    = 8'(col_q);
    pix_res.pixel_y    = row_q;
    pix_res.opaque     = (pix_q != 8'd0);
    if (pix_q != 8'd0) begin
      pix_res.red   = {pal_rdata_q[17:12], 2'b00};
      pix_res.green = {pal_rdata_q[11:6], 2'b00};
      pix_res.blue  = {pal_rdata_q[5:0], 2'b00};
    end
    pix_res.glow_index = (pix_q >= csd_pkg::GlowLo) && (pix_q <= csd_pkg::GlowHi);
    pix_res.any_glow   = glow_q;
    pix_res.last       = 1'b0;
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    bif_d       = bif_q;
    width_d     = width_q;
    height_d    = height_q;
    offset_d    = offset_q;
    col_d       = col_q;
    cand_d      = cand_q;
    row_d       = row_q;
    end_d       = end_q;
    lo_d        = lo_q;
    pix_d       = pix_q;
    glow_d      = glow_q;
    from_pix_d  = from_pix_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    fin_res     = '0;
    fin_res.last = 1'b1;
    pop_o       = 1'b0;
    col_we      = 1'b0;
    col_waddr   = col_q[ColIdxW-1:0];
    col_wdata   = {cmd_i.data_byte, lo_q};
    col_re      = 1'b0;
    col_raddr   = cand_q[ColIdxW-1:0];
    pal_we      = 1'b0;
    pal_re      = 1'b0;
    pal_raddr   = cmd_i.data_byte;

    case (state_q)
      csd_pkg::ST_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            csd_pkg::OP_PAL: begin
              pal_we = 1'b1;
            end
            csd_pkg::OP_RESTART: begin
              phase_d  = csd_pkg::PH_HEADER;
              bif_d    = '0;
              width_d  = '0;
              height_d = '0;
              offset_d = '0;
              col_d    = '0;
              row_d    = '0;
              glow_d   = 1'b0;
            end
            csd_pkg::OP_BYTE: begin
              case (phase_q)
                csd_pkg::PH_HEADER: begin
                  bif_d = 2'(bif_q + 2'd1);
                  case (bif_q)
                    2'd0:    height_d = {height_q[15:8], cmd_i.data_byte};
                    2'd1:    height_d = {cmd_i.data_byte, height_q[7:0]};
                    2'd2:    width_d  = {width_q[15:8], cmd_i.data_byte};
                    default: begin
                      width_d = width_new;
                      col_d   = '0;
                      if (width_new > 16'(MAX_COLUMNS)) begin
                        fin_res.kind = csd_pkg::KindTooWide;
                        out_d        = fin_res;
                        out_valid_d  = 1'b1;
                        phase_d      = csd_pkg::PH_DONE;
                      end else if (width_new == 16'd0) begin
                        fin_res.kind = csd_pkg::KindBadStart;
                        out_d        = fin_res;
                        out_valid_d  = 1'b1;
                        phase_d      = csd_pkg::PH_DONE;
                      end else begin
                        phase_d = csd_pkg::PH_ENTRIES;
                      end
                    end
                  endcase
                end
                csd_pkg::PH_ENTRIES: begin
                  bif_d = 2'(bif_q + 2'd1);
                  if (col_q == '0 && bif_q == 2'd0) begin
                    offset_d = {offset_q[15:8], cmd_i.data_byte};
                  end
                  if (col_q == '0 && bif_q == 2'd1) begin
                    offset_d = {cmd_i.data_byte, offset_q[7:0]};
                  end
                  if (bif_q == 2'd2) begin
                    lo_d = cmd_i.data_byte;
                  end
                  if (bif_q == 2'd3) begin
                    col_we = 1'b1;
                    col_d  = col_next;
                    if (16'(col_next) >= width_q) begin
                      if ({2'b00, offset_q} != expect_off) begin
                        fin_res.kind = csd_pkg::KindBadStart;
                        out_d        = fin_res;
                        out_valid_d  = 1'b1;
                        phase_d      = csd_pkg::PH_DONE;
                      end else begin
                        cand_d     = '0;
                        from_pix_d = 1'b0;
                        state_d    = csd_pkg::ST_RD;
                      end
                    end
                  end
                end
                csd_pkg::PH_PIXELS: begin
                  pal_re  = 1'b1;
                  pix_d   = cmd_i.data_byte;
                  glow_d  = glow_q || is_glow;
                  state_d = csd_pkg::ST_PIX;
                end
                default: begin
                end
              endcase
            end
            default: begin
            end
          endcase
        end
      end
      csd_pkg::ST_PIX: begin
        if (row_q != end_q) begin
          row_d       = 8'(row_q + 8'd1);
          out_d       = pix_res;
          out_valid_d = 1'b1;
          state_d     = csd_pkg::ST_IDLE;
        end else begin
          pend_d     = pix_res;
          cand_d     = col_next;
          from_pix_d = 1'b1;
          state_d    = csd_pkg::ST_RD;
        end
      end
      csd_pkg::ST_RD: begin
        if (16'(cand_q) >= width_q) begin
          phase_d     = csd_pkg::PH_DONE;
          out_valid_d = 1'b1;
          state_d     = csd_pkg::ST_IDLE;
          if (from_pix_q) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
          end else begin
            fin_res.kind = csd_pkg::KindEmpty;
            out_d        = fin_res;
          end
        end else begin
          col_re  = 1'b1;
          state_d = csd_pkg::ST_CHK;
        end
      end
      csd_pkg::ST_CHK: begin
        if (col_rdata_q[7:0] == csd_pkg::RowNone || col_rdata_q[7:0] > col_rdata_q[15:8]) begin
          cand_d  = CntW'(cand_q + 1'b1);
          state_d = csd_pkg::ST_RD;
        end else begin
          col_d   = cand_q;
          row_d   = col_rdata_q[7:0];
          end_d   = col_rdata_q[15:8];
          phase_d = csd_pkg::PH_PIXELS;
          state_d = csd_pkg::ST_IDLE;
          if (from_pix_q) begin
            out_d       = pend_q;
            out_valid_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = csd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csd_pkg::ST_IDLE;
      phase_q     <= csd_pkg::PH_HEADER;
      bif_q       <= '0;
      width_q     <= '0;
      height_q    <= '0;
      offset_q    <= '0;
      col_q       <= '0;
      cand_q      <= '0;
      row_q       <= '0;
      end_q       <= '0;
      glow_q      <= 1'b0;
      from_pix_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      bif_q       <= bif_d;
      width_q     <= width_d;
      height_q    <= height_d;
      offset_q    <= offset_d;
      col_q       <= col_d;
      cand_q      <= cand_d;
      row_q       <= row_d;
      end_q       <= end_d;
      glow_q      <= glow_d;
      from_pix_q  <= from_pix_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    pix_q  <= pix_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    if (col_re) begin
      col_rdata_q <= col_mem[col_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[cmd_i.pal_index] <= cmd_i.colour;
    end
    if (pal_re) begin
      pal_rdata_q <= pal_mem[pal_raddr];
    end
  end

  `CSD_ASSERT(a_busy_slot_empty, (state_q == csd_pkg::ST_IDLE) || !out_valid_q, "result pending while busy")
  `CSD_ASSERT(a_last_ends_sprite, !(out_valid_q && out_q.last) || (phase_q == csd_pkg::PH_DONE), "last result but sprite open")
  `CSD_ASSERT(a_pix_col_in_range, (phase_q != csd_pkg::PH_PIXELS) || (16'(col_q) < width_q), "pixel column beyond width")
  `CSD_ASSERT(a_width_checked, (phase_q != csd_pkg::PH_ENTRIES) || ((width_q != 16'd0) && (width_q <= 16'(MAX_COLUMNS))), "entries with bad width")
  `CSD_ASSERT_NEXT(a_pix_follows_read, (state_q == csd_pkg::ST_IDLE) && pal_re, state_q == csd_pkg::ST_PIX, "palette read not followed")

endmodule

`default_nettype wire

// File: rtl/column_span_sprite_decoder.sv
// channel  | direction | handshake                 | payload
// in       | input     | in_valid_i / in_stall_o   | in_i  (csd_in_t)
// out      | output    | out_valid_o / out_stall_i | out_o (csd_out_t)
//
// palette write, restart, header or column entry byte: taken by the back end in its idle state
// pixel byte: the palette read is registered, then the result is formed in the pixel state
// at a column end or after the last entry: a read and a check state per column examined,
// and a last read state when no column is left
// a two-entry queue parts input from the back end; the result register holds under stall
// reset clears the parser and counters; the palette and column stores are not cleared
`default_nettype none

module column_span_sprite_decoder #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire csd_pkg::csd_in_t in_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output csd_pkg::csd_out_t     out_o
);

  csd_pkg::csd_push_t push;
  csd_pkg::csd_cmd_t  cmd;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;

  csd_front u_front (
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .in_stall_o (in_stall_o)
  );

  csd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (cmd)
  );

  csd_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (cmd),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// File: bench/column_span_sprite_decoder_tb.sv
`timescale 1ns / 1ps

module column_span_sprite_decoder_tb;

  localparam int unsigned MaxColumns  = 32;
  localparam int unsigned EntryBytes  = 4;
  localparam int unsigned DrainCycles = 600;
  localparam int unsigned StallLimit  = 10000;
  localparam logic [1:0]  ModeUnused  = 2'd3;

  class sprite_scoreboard;
    logic [17:0]          palette [256];
    logic [15:0]          col_rows [256];
    csd_pkg::csd_phase_e  phase;
    logic [1:0]           field_pos;
    logic [15:0]          width;
    logic [15:0]          height;
    logic [15:0]          first_off;
    logic [8:0]           col;
    logic [7:0]           row;
    logic                 glow_seen;
    csd_pkg::csd_out_t    results_due [$];
    int unsigned          errors;

    function new();
      errors = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      phase     = csd_pkg::PH_HEADER;
      field_pos = 2'd0;
      width     = 16'd0;
      height    = 16'd0;
      first_off = 16'd0;
      col       = 9'd0;
      row       = 8'd0;
      glow_seen = 1'b0;
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    function bit column_empty(logic [7:0] c);
      return col_rows[c][7:0] == csd_pkg::RowNone || col_rows[c][7:0] > col_rows[c][15:8];
    endfunction

    function logic [8:0] skip_empty(logic [8:0] c);
      while (c < width && column_empty(c[7:0])) c++;
      return c;
    endfunction

    function void end_sprite(logic [1:0] kind);
      csd_pkg::csd_out_t r;
      r = '0;
      r.kind = kind;
      r.last = 1'b1;
      results_due.push_back(r);
      phase = csd_pkg::PH_DONE;
    endfunction

    function void decode_item(csd_pkg::csd_in_t it);
      logic [7:0]        b;
      logic [17:0]       rgb;
      csd_pkg::csd_out_t r;
      b = it.data_byte;
      if (it.mode == csd_pkg::ModePal) begin
        palette[it.pal_index] = {it.pal_red, it.pal_green, it.pal_blue};
      end else if (it.mode == csd_pkg::ModeRestart) begin
        clear_parser();
      end else if (it.mode == csd_pkg::ModeByte) begin
        case (phase)
          csd_pkg::PH_HEADER: begin
            case (field_pos)
              2'd0: height[7:0] = b;
              2'd1: height[15:8] = b;
              2'd2: width[7:0] = b;
              default: width[15:8] = b;
            endcase
            field_pos++;
            if (field_pos == 2'd0) begin
              if (width > MaxColumns) begin
                end_sprite(csd_pkg::KindTooWide);
              end else if (width == 16'd0) begin
                end_sprite(csd_pkg::KindBadStart);
              end else begin
                col   = 9'd0;
                phase = csd_pkg::PH_ENTRIES;
              end
            end
          end
          csd_pkg::PH_ENTRIES: begin
            if (col == 9'd0 && field_pos == 2'd0) first_off[7:0] = b;
            else if (col == 9'd0 && field_pos == 2'd1) first_off[15:8] = b;
            else if (field_pos == 2'd2) col_rows[col[7:0]][7:0] = b;
            else if (field_pos == 2'd3) col_rows[col[7:0]][15:8] = b;
            field_pos++;
            if (field_pos == 2'd0) begin
              col++;
              if (col >= width) begin
                if (int'(first_off) !=
                    int'(csd_pkg::HeaderBytes) + EntryBytes * int'(width)) begin
                  end_sprite(csd_pkg::KindBadStart);
                end else begin
                  col = skip_empty(9'd0);
                  if (col >= width) begin
                    end_sprite(csd_pkg::KindEmpty);
                  end else begin
                    row   = col_rows[col[7:0]][7:0];
                    phase = csd_pkg::PH_PIXELS;
                  end
                end
              end
            end
          end
          csd_pkg::PH_PIXELS: begin
            rgb       = palette[b];
            r         = '0;
            r.kind    = csd_pkg::KindPixel;
            r.pixel_x = col[7:0];
            r.pixel_y = row;
            r.opaque  = (b != 8'd0);
            if (r.opaque) begin
              r.red   = {rgb[17:12], 2'b00};
              r.green = {rgb[11:6], 2'b00};
              r.blue  = {rgb[5:0], 2'b00};
            end
            r.glow_index = (b >= csd_pkg::GlowLo && b <= csd_pkg::GlowHi);
            if (r.glow_index) glow_seen = 1'b1;
            r.any_glow = glow_seen;
            if (row != col_rows[col[7:0]][15:8]) begin
              row++;
            end else begin
              col = skip_empty(col + 9'd1);
              if (col >= width) begin
                r.last = 1'b1;
                phase  = csd_pkg::PH_DONE;
              end else begin
                row = col_rows[col[7:0]][7:0];
              end
            end
            results_due.push_back(r);
          end
          default: ;
        endcase
      end
    endfunction

    function void note_input(csd_pkg::csd_in_t it);
      decode_item(it);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s expected %0d got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(csd_pkg::csd_out_t got);
      csd_pkg::csd_out_t want;
      if (results_due.size() == 0) begin
        $error("result with nothing pending: %h", got);
        errors++;
        return;
      end
      want = results_due.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("pixel_x", want.pixel_x, got.pixel_x);
      compare_field("pixel_y", want.pixel_y, got.pixel_y);
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("opaque", want.opaque, got.opaque);
      compare_field("glow_index", want.glow_index, got.glow_index);
      compare_field("any_glow", want.any_glow, got.any_glow);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  csd_pkg::csd_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  csd_pkg::csd_out_t out_data;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned item_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_by_phase [4] = '{0, 72, 0, 22};
  int unsigned stall_by_phase [4] = '{0, 0, 72, 22};
  logic [7:0]  sprite_bytes [$];

  sprite_scoreboard sb = new();

  column_span_sprite_decoder #(
    .MAX_COLUMNS(MaxColumns)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // results first so a transaction accepted at the same edge cannot absorb one
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
          $display("[column_span_sprite_decoder] ERROR");
          $finish;
        end
      end
    end
  end

  function automatic csd_pkg::csd_in_t mk_item(logic [1:0] m, logic [7:0] b);
    csd_pkg::csd_in_t it;
    it.mode      = m;
    it.data_byte = b;
    it.pal_index = 8'($urandom_range(255));
    it.pal_red   = 6'($urandom_range(63));
    it.pal_green = 6'($urandom_range(63));
    it.pal_blue  = 6'($urandom_range(63));
    return it;
  endfunction

  function automatic csd_pkg::csd_in_t pal_item(logic [7:0] idx, logic [5:0] r,
                                                logic [5:0] g, logic [5:0] bl);
    csd_pkg::csd_in_t it;
    it = mk_item(csd_pkg::ModePal, 8'($urandom_range(255)));
    it.pal_index = idx;
    it.pal_red   = r;
    it.pal_green = g;
    it.pal_blue  = bl;
    return it;
  endfunction

  function automatic logic [7:0] pick_pixel_index();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'($urandom_range(csd_pkg::GlowLo, csd_pkg::GlowHi));
      2: return $urandom_range(1) ? csd_pkg::GlowLo - 8'd1 : csd_pkg::GlowHi + 8'd1;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send(csd_pkg::csd_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.mode != ModeUnused) item_count++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic build_sprite(logic [15:0] w, int unsigned empty_pct, bit wrong_offset,
                              bit full_first, bit header_only);
    logic [15:0] h;
    logic [15:0] off;
    logic [7:0]  s;
    logic [7:0]  e;
    logic [7:0]  starts [$];
    logic [7:0]  ends [$];
    h = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(8));
    off = 16'(int'(csd_pkg::HeaderBytes) + EntryBytes * int'(w));
    if (wrong_offset) off = off ^ 16'($urandom_range(1, 65535));
    sprite_bytes = {h[7:0], h[15:8], w[7:0], w[15:8]};
    if (header_only) return;
    for (int c = 0; c < int'(w); c++) begin
      if (full_first && c == 0) begin
        s = 8'd0;
        e = csd_pkg::RowNone;
      end else if ($urandom_range(99) < empty_pct) begin
        if ($urandom_range(1) == 0) begin
          s = csd_pkg::RowNone;
          e = 8'($urandom_range(255));
        end else begin
          s = 8'($urandom_range(1, 254));
          e = 8'($urandom_range(s - 1));
        end
      end else begin
        s = 8'($urandom_range(254));
        e = (s > 8'd250) ? csd_pkg::RowNone : s + 8'($urandom_range(4));
      end
      if (c == 0) begin
        sprite_bytes.push_back(off[7:0]);
        sprite_bytes.push_back(off[15:8]);
      end else begin
        sprite_bytes.push_back(8'($urandom_range(255)));
        sprite_bytes.push_back(8'($urandom_range(255)));
      end
      sprite_bytes.push_back(s);
      sprite_bytes.push_back(e);
      starts.push_back(s);
      ends.push_back(e);
    end
    for (int c = 0; c < int'(w); c++) begin
      if (!(starts[c] == csd_pkg::RowNone || starts[c] > ends[c])) begin
        for (int y = starts[c]; y <= ends[c]; y++) sprite_bytes.push_back(pick_pixel_index());
      end
    end
  endtask

  task automatic send_stream(int unsigned n);
    for (int unsigned i = 0; i < n && i < sprite_bytes.size(); i++) begin
      if ($urandom_range(99) < 4) begin
        send(pal_item(8'($urandom_range(255)), 6'($urandom_range(63)),
                      6'($urandom_range(63)), 6'($urandom_range(63))));
      end else if ($urandom_range(99) < 2) begin
        send(mk_item(ModeUnused, 8'($urandom_range(255))));
      end
      send(mk_item(csd_pkg::ModeByte, sprite_bytes[i]));
    end
  endtask

  task automatic random_sprites(int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    logic [15:0] w;
    stop_at = item_count + quota;
    while (item_count < stop_at) begin
      send(mk_item(csd_pkg::ModeRestart, 8'($urandom_range(255))));
      pick = $urandom_range(99);
      w = ($urandom_range(9) == 0) ? 16'($urandom_range(7, 24)) : 16'($urandom_range(1, 6));
      if (pick < 66) begin
        build_sprite(w, 25, 1'b0, 1'b0, 1'b0);
        send_stream(sprite_bytes.size());
      end else if (pick < 73) begin
        case ($urandom_range(2))
          0: w = 16'(MaxColumns + 1);
          1: w = 16'hFFFF;
          default: w = 16'($urandom_range(MaxColumns + 1, 65535));
        endcase
        build_sprite(w, 0, 1'b0, 1'b0, 1'b1);
        send_stream(sprite_bytes.size());
      end else if (pick < 78) begin
        build_sprite(16'd0, 0, 1'b0, 1'b0, 1'b1);
        send_stream(sprite_bytes.size());
      end else if (pick < 84) begin
        build_sprite(w, 25, 1'b1, 1'b0, 1'b0);
        send_stream(sprite_bytes.size());
      end else if (pick < 90) begin
        build_sprite(w, 100, 1'b0, 1'b0, 1'b0);
        send_stream(sprite_bytes.size());
      end else begin
        build_sprite(w, 25, 1'b0, 1'b0, 1'b0);
        send_stream($urandom_range(sprite_bytes.size() - 1));
      end
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send(mk_item(csd_pkg::ModeByte, 8'($urandom_range(255))));
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 256; i++) begin
      if (i == 0) send(pal_item(8'd0, 6'd0, 6'd0, 6'd0));
      else if (i == 255) send(pal_item(8'd255, 6'h3F, 6'h3F, 6'h3F));
      else send(pal_item(8'(i), 6'($urandom_range(63)), 6'($urandom_range(63)),
                         6'($urandom_range(63))));
    end

    // two columns, second empty; rows run past the height; transparent and glow edges
    sprite_bytes = {8'd2, 8'd0, 8'd2, 8'd0,
                    8'd12, 8'd0, 8'd0, 8'd3,
                    8'($urandom_range(255)), 8'($urandom_range(255)),
                    csd_pkg::RowNone, csd_pkg::RowNone,
                    8'd0, csd_pkg::GlowLo, csd_pkg::GlowHi};
    send_stream(0);
    foreach (sprite_bytes[i]) send(mk_item(csd_pkg::ModeByte, sprite_bytes[i]));
    send(pal_item(8'd255, 6'h2A, 6'h15, 6'h3F));
    send(mk_item(csd_pkg::ModeByte, 8'd255));
    send(mk_item(csd_pkg::ModeByte, 8'($urandom_range(255))));
    send(mk_item(ModeUnused, 8'($urandom_range(255))));
    send(mk_item(csd_pkg::ModeRestart, 8'($urandom_range(255))));
    send(mk_item(csd_pkg::ModeByte, 8'hFF));
    send(mk_item(csd_pkg::ModeByte, 8'hFF));
    send(mk_item(csd_pkg::ModeByte, 8'h01));
    send(mk_item(csd_pkg::ModeByte, 8'h01));
    wait_for_results();

    // widest sprite, a full-height first column and long runs of empty columns
    send(mk_item(csd_pkg::ModeRestart, 8'($urandom_range(255))));
    build_sprite(16'(MaxColumns), 98, 1'b0, 1'b1, 1'b0);
    send_stream(sprite_bytes.size());
    wait_for_results();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      random_sprites(60);
      wait_for_results();
    end

    if (sb.errors == 0) begin
      $display("[column_span_sprite_decoder] OK");
    end else begin
      $display("[column_span_sprite_decoder] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/csd_pkg.sv
rtl/csd_front.sv
rtl/csd_queue.sv
rtl/csd_back.sv
rtl/column_span_sprite_decoder.sv
bench/column_span_sprite_decoder_tb.sv
